FILE: hdl/lwbc_pkg.sv
// ----------------------------------------------------------------------------
// lwbc_pkg
// request and status codes, result record and controller states shared by
// the cache directory files
// ----------------------------------------------------------------------------
package lwbc_pkg;

    localparam int unsigned TAG_W       = 32;
    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned CNT_W       = 3;

    typedef enum logic [1:0] {
        REQ_LOOKUP       = 2'd0,
        REQ_MARK_DIRTY   = 2'd1,
        REQ_FLUSH        = 2'd2,
        REQ_FETCH_FAILED = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        STS_HIT         = 3'd0,
        STS_FILLED      = 3'd1,
        STS_NOT_FOUND   = 3'd2,
        STS_RANGE_ERR   = 3'd3,
        STS_FLUSH_STEP  = 3'd4,
        STS_INVALIDATED = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        FSM_IDLE  = 4'b0001,
        FSM_LOOK  = 4'b0010,
        FSM_UPD   = 4'b0100,
        FSM_FLUSH = 4'b1000
    } fsm_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [2:0]       slot;
        logic             writeback_valid;
        logic [TAG_W-1:0] writeback_block;
        logic             fetch_valid;
        logic [TAG_W-1:0] fetch_block;
        logic             last;
    } rsp_t;

endpackage

FILE: hdl/lwbc_ifs.sv
// ----------------------------------------------------------------------------
// lwbc interfaces
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface lwbc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] block_number;
    logic [2:0]  slot_index;

    modport source (output valid, output req_type, output block_number,
                    output slot_index, input ready);
    modport sink (input valid, input req_type, input block_number,
                  input slot_index, output ready);
endinterface

interface lwbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  slot;
    logic        writeback_valid;
    logic [31:0] writeback_block;
    logic        fetch_valid;
    logic [31:0] fetch_block;
    logic        last;

    modport source (output valid, output status, output slot,
                    output writeback_valid, output writeback_block,
                    output fetch_valid, output fetch_block, output last,
                    input ready);
    modport sink (input valid, input status, input slot,
                  input writeback_valid, input writeback_block,
                  input fetch_valid, input fetch_block, input last,
                  output ready);
endinterface

FILE: hdl/lwbc_tag_ram.sv
// ----------------------------------------------------------------------------
// lwbc_tag_ram
// tag store, one entry per slot, whole row read back each cycle with the
// current write forwarded into the read register
// ----------------------------------------------------------------------------
module lwbc_tag_ram #(
    parameter int unsigned WAYS = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] waddr,
    input  logic [lwbc_pkg::TAG_W-1:0]               wdata,
    output logic [WAYS-1:0][lwbc_pkg::TAG_W-1:0]     rd_row
);

    localparam int unsigned SW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [lwbc_pkg::TAG_W-1:0]           mem [WAYS];
    logic [WAYS-1:0][lwbc_pkg::TAG_W-1:0] rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            if (we && (waddr == SW'(i)))
            begin
                rd_row_reg[i] <= wdata;
            end
            else
            begin
                rd_row_reg[i] <= mem[i];
            end
        end
    end

    assign rd_row = rd_row_reg;

endmodule

FILE: hdl/lwbc_match.sv
// ----------------------------------------------------------------------------
// lwbc_match
// parallel tag compare over all slots, registered hit flag and recency
// position of the hit
// ----------------------------------------------------------------------------
module lwbc_match #(
    parameter int unsigned WAYS = 8
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic [WAYS-1:0][lwbc_pkg::TAG_W-1:0]       tag_row,
    input  logic [WAYS-1:0]                            valid_vec,
    input  logic [WAYS-1:0][((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] order,
    input  logic [lwbc_pkg::TAG_W-1:0]                 blk,
    output logic                                       hit,
    output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] hit_pos
);

    localparam int unsigned SW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [WAYS-1:0] slot_hit;
    logic            hit_next;
    logic [SW-1:0]   hit_pos_next;
    logic            hit_reg;
    logic [SW-1:0]   hit_pos_reg;

    always_comb
    begin
        hit_pos_next = '0;
        for (int s = 0; s < WAYS; s++)
        begin
            slot_hit[s] = valid_vec[s] && (tag_row[s] == blk);
        end
        hit_next = |slot_hit;
        for (int p = 0; p < WAYS; p++)
        begin
            if (slot_hit[order[p]])
            begin
                hit_pos_next = SW'(p);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg     <= 1'b0;
            hit_pos_reg <= '0;
        end
        else
        begin
            hit_reg     <= hit_next;
            hit_pos_reg <= hit_pos_next;
        end
    end

    assign hit     = hit_reg;
    assign hit_pos = hit_pos_reg;

endmodule

FILE: hdl/lru_writeback_block_cache_directory.sv
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_directory
// directory of a fully associative block cache with lru order and write-back
// ----------------------------------------------------------------------------
// Lookup, mark-dirty and fetch-failed requests pass a compare state and then
// an update state: in the compare state the registered tag row from the tag
// store is compared against the block on all slots at once, in the update
// state the recency list, valid and dirty bits and the tag store are updated
// and the result goes to the output register. A new request is taken in the
// update state, as the last result goes to the output register. A flush
// walks the recency positions from the most recent slot down to the last
// dirty one it reports, at most eight results. A stalled result holds the
// update state. The slot field carries the low three bits of the slot
// number. Tags need no clearing after reset: a tag is only read for a valid
// slot.
// ----------------------------------------------------------------------------
module lru_writeback_block_cache_directory #(
    parameter int unsigned WAYS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    lwbc_req_if.sink    req,
    lwbc_rsp_if.source  rsp
);

    localparam int unsigned SW = (WAYS > 1) ? $clog2(WAYS) : 1;

    lwbc_pkg::fsm_t                       state_reg, state_next;
    lwbc_pkg::req_t                       req_reg;
    logic [lwbc_pkg::TAG_W-1:0]           blk_reg;
    logic [2:0]                           sidx_reg;
    logic [31:0]                          table_blocks_reg;

    logic [WAYS-1:0][SW-1:0]              order_reg, order_next;
    logic [WAYS-1:0]                      valid_reg, valid_next;
    logic [WAYS-1:0]                      dirty_reg, dirty_next;
    logic [SW-1:0]                        pos_reg, pos_next;
    logic [lwbc_pkg::CNT_W-1:0]           cnt_reg, cnt_next;

    lwbc_pkg::rsp_t                       out_reg, out_next;
    logic                                 out_valid_reg, out_valid_next;
    lwbc_pkg::rsp_t                       res;

    logic                                 tag_we;
    logic [SW-1:0]                        tag_waddr;
    logic [WAYS-1:0][lwbc_pkg::TAG_W-1:0] tag_row;

    logic                                 hit;
    logic [SW-1:0]                        hit_pos;

    logic                                 out_free;
    logic                                 in_accept;
    logic [WAYS-1:0]                      vd;
    logic                                 any_dirty;
    logic [SW-1:0]                        hit_slot;
    logic [SW-1:0]                        lru_slot;
    logic [SW-1:0]                        fs;
    logic                                 fs_dirty;
    logic                                 dirty_below;
    logic                                 flush_last;
    logic [SW-1:0]                        sidx_w;
    logic                                 sidx_ok;
    logic [SW-1:0]                        ff_pos;
    logic                                 mru_en;
    logic                                 lru_en;
    logic [SW-1:0]                        mv_pos;

    lwbc_tag_ram #(.WAYS(WAYS)) u_tag_ram (
        .clk    (clk),
        .we     (tag_we),
        .waddr  (tag_waddr),
        .wdata  (blk_reg),
        .rd_row (tag_row)
    );

    lwbc_match #(.WAYS(WAYS)) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_row   (tag_row),
        .valid_vec (valid_reg),
        .order     (order_reg),
        .blk       (blk_reg),
        .hit       (hit),
        .hit_pos   (hit_pos)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == lwbc_pkg::FSM_IDLE)
                    || ((state_reg == lwbc_pkg::FSM_UPD) && out_free);
    assign in_accept = req.valid && req.ready;

    assign vd        = valid_reg & dirty_reg;
    assign any_dirty = |vd;
    assign hit_slot  = order_reg[hit_pos];
    assign lru_slot  = order_reg[0];
    assign fs        = order_reg[pos_reg];
    assign fs_dirty  = vd[fs];
    assign sidx_w    = SW'(sidx_reg);
    assign sidx_ok   = 32'(sidx_reg) < 32'(WAYS);
    assign tag_waddr = lru_slot;

    always_comb
    begin
        dirty_below = 1'b0;
        ff_pos      = '0;
        for (int q = 0; q < WAYS; q++)
        begin
            if (SW'(q) < pos_reg)
            begin
                dirty_below = dirty_below | vd[order_reg[q]];
            end
            if (order_reg[q] == sidx_w)
            begin
                ff_pos = SW'(q);
            end
        end
    end

    assign flush_last = (cnt_reg == lwbc_pkg::CNT_W'(lwbc_pkg::MAX_RESULTS - 1))
                     || !dirty_below;

    // recency list moves
    always_comb
    begin
        order_next = order_reg;
        if (mru_en)
        begin
            for (int i = 0; i < WAYS - 1; i++)
            begin
                if (SW'(i) >= mv_pos)
                begin
                    order_next[i] = order_reg[i + 1];
                end
            end
            order_next[WAYS-1] = order_reg[mv_pos];
        end
        else if (lru_en)
        begin
            for (int i = 1; i < WAYS; i++)
            begin
                if (SW'(i) <= mv_pos)
                begin
                    order_next[i] = order_reg[i - 1];
                end
            end
            order_next[0] = order_reg[mv_pos];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mru_en         = 1'b0;
        lru_en         = 1'b0;
        mv_pos         = '0;
        tag_we         = 1'b0;
        res            = '0;

        case (state_reg)
            lwbc_pkg::FSM_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = lwbc_pkg::FSM_LOOK;
                end
            end

            lwbc_pkg::FSM_LOOK:
            begin
                if ((req_reg == lwbc_pkg::REQ_FLUSH) && any_dirty)
                begin
                    state_next = lwbc_pkg::FSM_FLUSH;
                    pos_next   = SW'(WAYS - 1);
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = lwbc_pkg::FSM_UPD;
                end
            end

            lwbc_pkg::FSM_UPD:
            begin
                if (out_free)
                begin
                    res.last = 1'b1;
                    case (req_reg)
                        lwbc_pkg::REQ_LOOKUP:
                        begin
                            if (hit)
                            begin
                                mru_en     = 1'b1;
                                mv_pos     = hit_pos;
                                res.status = lwbc_pkg::STS_HIT;
                                res.slot   = 3'(hit_slot);
                            end
                            else
                            begin
                                res.slot            = 3'(lru_slot);
                                res.writeback_valid = vd[lru_slot];
                                res.writeback_block = vd[lru_slot] ? tag_row[lru_slot] : '0;
                                dirty_next[lru_slot] = 1'b0;
                                if (blk_reg >= table_blocks_reg)
                                begin
                                    valid_next[lru_slot] = 1'b0;
                                    res.status           = lwbc_pkg::STS_RANGE_ERR;
                                end
                                else
                                begin
                                    tag_we               = 1'b1;
                                    valid_next[lru_slot] = 1'b1;
                                    mru_en               = 1'b1;
                                    mv_pos               = '0;
                                    res.status           = lwbc_pkg::STS_FILLED;
                                    res.fetch_valid      = 1'b1;
                                    res.fetch_block      = blk_reg;
                                end
                            end
                        end

                        lwbc_pkg::REQ_MARK_DIRTY:
                        begin
                            if (hit)
                            begin
                                dirty_next[hit_slot] = 1'b1;
                                mru_en               = 1'b1;
                                mv_pos               = hit_pos;
                                res.status           = lwbc_pkg::STS_HIT;
                                res.slot             = 3'(hit_slot);
                            end
                            else
                            begin
                                res.status = lwbc_pkg::STS_NOT_FOUND;
                            end
                        end

                        lwbc_pkg::REQ_FLUSH:
                        begin
                            res.status = lwbc_pkg::STS_FLUSH_STEP;
                        end

                        lwbc_pkg::REQ_FETCH_FAILED:
                        begin
                            res.slot = sidx_reg;
                            if (sidx_ok)
                            begin
                                valid_next[sidx_w] = 1'b0;
                                dirty_next[sidx_w] = 1'b0;
                                lru_en             = 1'b1;
                                mv_pos             = ff_pos;
                                res.status         = lwbc_pkg::STS_INVALIDATED;
                            end
                            else
                            begin
                                res.status = lwbc_pkg::STS_NOT_FOUND;
                            end
                        end

                        default:
                        begin
                            res.status = lwbc_pkg::STS_NOT_FOUND;
                        end
                    endcase
                    out_next       = res;
                    out_valid_next = 1'b1;
                    state_next     = in_accept ? lwbc_pkg::FSM_LOOK : lwbc_pkg::FSM_IDLE;
                end
            end

            lwbc_pkg::FSM_FLUSH:
            begin
                if (fs_dirty)
                begin
                    if (out_free)
                    begin
                        res.status          = lwbc_pkg::STS_FLUSH_STEP;
                        res.slot            = 3'(fs);
                        res.writeback_valid = 1'b1;
                        res.writeback_block = tag_row[fs];
                        res.last            = flush_last;
                        out_next            = res;
                        out_valid_next      = 1'b1;
                        dirty_next[fs]      = 1'b0;
                        cnt_next            = cnt_reg + 1'b1;
                        if (flush_last)
                        begin
                            state_next = lwbc_pkg::FSM_IDLE;
                        end
                        else
                        begin
                            pos_next = pos_reg - 1'b1;
                        end
                    end
                end
                else
                begin
                    pos_next = pos_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = lwbc_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lwbc_pkg::FSM_IDLE;
            valid_reg        <= '0;
            dirty_reg        <= '0;
            pos_reg          <= '0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            table_blocks_reg <= '0;
            for (int i = 0; i < WAYS; i++)
            begin
                order_reg[i] <= SW'(i);
            end
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            order_reg     <= order_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                table_blocks_reg <= cfg_wdata;
            end
        end
    end

    // item payload and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg  <= lwbc_pkg::req_t'(req.req_type);
            blk_reg  <= req.block_number;
            sidx_reg <= req.slot_index;
        end
        out_reg <= out_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.slot            = out_reg.slot;
    assign rsp.writeback_valid = out_reg.writeback_valid;
    assign rsp.writeback_block = out_reg.writeback_block;
    assign rsp.fetch_valid     = out_reg.fetch_valid;
    assign rsp.fetch_block     = out_reg.fetch_block;
    assign rsp.last            = out_reg.last;

endmodule

FILE: hdl/lwbc_checker.sv
// ----------------------------------------------------------------------------
// lwbc_checker
// port-level checks on the result channel of the cache directory
// ----------------------------------------------------------------------------
module lwbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [2:0]  slot,
    input logic        writeback_valid,
    input logic [31:0] writeback_block,
    input logic        fetch_valid,
    input logic [31:0] fetch_block,
    input logic        last
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(slot)
            && $stable(writeback_valid) && $stable(writeback_block)
            && $stable(fetch_valid) && $stable(fetch_block) && $stable(last))
        else $error("result item changed while stalled");

    // a fetch goes out exactly with a filled miss
    a_fetch_filled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fetch_valid == (status == lwbc_pkg::STS_FILLED)))
        else $error("fetch request does not match status");

    // only a flush run emits non-final items, each with a write-back
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> (status == lwbc_pkg::STS_FLUSH_STEP) && writeback_valid)
        else $error("non-final item outside a flush run");

endmodule

bind lru_writeback_block_cache_directory lwbc_checker u_lwbc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .status          (rsp.status),
    .slot            (rsp.slot),
    .writeback_valid (rsp.writeback_valid),
    .writeback_block (rsp.writeback_block),
    .fetch_valid     (rsp.fetch_valid),
    .fetch_block     (rsp.fetch_block),
    .last            (rsp.last)
);
